// ----- hw/rtl/gclu_pkg.sv -----
// ----------------------------------------------------------------------------
// gclu_pkg
// Shared types for the gcd/lcm unit: sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package gclu_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_MULB,
    ST_DIV,
    ST_MULL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gcd_lcm_unit.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// GCD, wrapped LCM and product-overflow flag of two unsigned operands, worked
// out on one shared add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: accept, binary-GCD steps, a*b on the shared adder (its high half
//   gives the flag), restoring divide of a by the GCD, then (a/g)*b for the
//   wrapped LCM; one zero operand skips straight to the result.
// Flow: one transaction at a time; multiply and restoring divide use the
//   shared adder for one bit a cycle, and GCD steps use it to subtract.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
`default_nettype none

module gcd_lcm_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [DATA_WIDTH-1:0] in_operand_a,
  input  wire  [DATA_WIDTH-1:0] in_operand_b,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [DATA_WIDTH-1:0] out_gcd_value,
  output logic [DATA_WIDTH-1:0] out_lcm_value,
  output logic                  out_product_overflows
);

  localparam int W  = DATA_WIDTH;
  localparam int KW = $clog2(DATA_WIDTH);
  localparam int CW = $clog2(DATA_WIDTH);

  gclu_pkg::state_t state_r, state_nxt;

  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]  u_r, u_nxt, v_r, v_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [W-1:0]  g_r, g_nxt;
  logic [W-1:0]  hi_r, hi_nxt, lo_r, lo_nxt;
  logic [W-1:0]  mcand_r, mcand_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // shared add/subtract unit
  logic [W+1:0] alu_x, alu_y, alu_res;
  logic         alu_sub;

  logic         in_acc, zero_op, u_ge_v, u_eq_v, cnt_last;
  logic [W:0]   div_shift;

  assign in_acc   = in_valid && in_ready;
  assign zero_op  = (in_operand_a == '0) || (in_operand_b == '0);
  assign u_ge_v   = (u_r >= v_r);
  assign u_eq_v   = (u_r == v_r);
  assign cnt_last = (cnt_r == '0);
  assign div_shift = {hi_r, lo_r[W-1]};

  assign alu_res = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

  // operand select for the shared unit
  always_comb begin
    alu_sub = 1'b0;
    alu_x   = '0;
    alu_y   = '0;
    unique case (state_r)
      gclu_pkg::ST_GCD: begin
        alu_sub = 1'b1;
        alu_x   = u_ge_v ? {2'b00, u_r} : {2'b00, v_r};
        alu_y   = u_ge_v ? {2'b00, v_r} : {2'b00, u_r};
      end
      gclu_pkg::ST_MULB, gclu_pkg::ST_MULL: begin
        alu_x = {2'b00, hi_r};
        alu_y = lo_r[0] ? {2'b00, mcand_r} : '0;
      end
      gclu_pkg::ST_DIV: begin
        alu_sub = 1'b1;
        alu_x   = {1'b0, div_shift};
        alu_y   = {2'b00, g_r};
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gclu_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = zero_op ? gclu_pkg::ST_DONE : gclu_pkg::ST_GCD;
      end
      gclu_pkg::ST_GCD: begin
        if (u_eq_v) state_nxt = gclu_pkg::ST_MULB;
      end
      gclu_pkg::ST_MULB: begin
        if (cnt_last) state_nxt = gclu_pkg::ST_DIV;
      end
      gclu_pkg::ST_DIV: begin
        if (cnt_last) state_nxt = gclu_pkg::ST_MULL;
      end
      gclu_pkg::ST_MULL: begin
        if (cnt_last) state_nxt = gclu_pkg::ST_DONE;
      end
      gclu_pkg::ST_DONE: begin
        if (out_ready) state_nxt = gclu_pkg::ST_IDLE;
      end
      default: state_nxt = gclu_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    mcand_nxt = mcand_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    in_ready  = (state_r == gclu_pkg::ST_IDLE);
    out_valid = (state_r == gclu_pkg::ST_DONE);
    unique case (state_r)
      gclu_pkg::ST_IDLE: begin
        if (in_acc) begin
          a_nxt   = in_operand_a;
          b_nxt   = in_operand_b;
          u_nxt   = in_operand_a;
          v_nxt   = in_operand_b;
          k_nxt   = '0;
          // one operand zero: gcd is the other, lcm and flag are zero
          g_nxt   = in_operand_a | in_operand_b;
          lo_nxt  = '0;
          ovf_nxt = 1'b0;
        end
      end
      gclu_pkg::ST_GCD: begin
        if (u_eq_v) begin
          g_nxt     = u_r << k_r;
          hi_nxt    = '0;
          lo_nxt    = b_r;
          mcand_nxt = a_r;
          cnt_nxt   = CW'(W - 1);
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + KW'(1);
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_ge_v) begin
          u_nxt = alu_res[W-1:0];
        end else begin
          v_nxt = alu_res[W-1:0];
        end
      end
      gclu_pkg::ST_MULB, gclu_pkg::ST_MULL: begin
        // shift-add: accumulate into the high half, shift the pair right
        hi_nxt  = alu_res[W:1];
        lo_nxt  = {alu_res[0], lo_r[W-1:1]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_last && (state_r == gclu_pkg::ST_MULB)) begin
          ovf_nxt = (alu_res[W:1] != '0);
          hi_nxt  = '0;
          lo_nxt  = a_r;
          cnt_nxt = CW'(W - 1);
        end
      end
      gclu_pkg::ST_DIV: begin
        // restoring divide of a by g, quotient builds in lo
        cnt_nxt = cnt_r - CW'(1);
        if (!alu_res[W+1]) begin
          hi_nxt = alu_res[W-1:0];
          lo_nxt = {lo_r[W-2:0], 1'b1};
        end else begin
          hi_nxt = div_shift[W-1:0];
          lo_nxt = {lo_r[W-2:0], 1'b0};
        end
        if (cnt_last) begin
          mcand_nxt = {lo_r[W-2:0], !alu_res[W+1]};
          hi_nxt    = '0;
          lo_nxt    = b_r;
          cnt_nxt   = CW'(W - 1);
        end
      end
      gclu_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gclu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    k_r     <= k_nxt;
    g_r     <= g_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    mcand_r <= mcand_nxt;
    ovf_r   <= ovf_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign out_gcd_value         = g_r;
  assign out_lcm_value         = lo_r;
  assign out_product_overflows = ovf_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gclu_checker.sv -----
// ----------------------------------------------------------------------------
// gclu_checker
// Port-level checks on the gcd/lcm unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gclu_checker #(
  parameter int DATA_WIDTH = 64
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire [DATA_WIDTH-1:0] in_operand_a,
  input wire [DATA_WIDTH-1:0] in_operand_b,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [DATA_WIDTH-1:0] out_gcd_value,
  input wire [DATA_WIDTH-1:0] out_lcm_value,
  input wire                  out_product_overflows
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gcd_value)
      && $stable(out_lcm_value) && $stable(out_product_overflows))
    else $error("result changed while stalled");

  // one transaction in flight: never ready while a result is shown
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready while result pending");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after accept");

  // gcd of zero only for both operands zero, which forces zero lcm and flag
  a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gcd_value == '0) |-> (out_lcm_value == '0) && !out_product_overflows)
    else $error("zero gcd with nonzero lcm or flag");

  // two nonzero operands go through the GCD loop, so no result next cycle
  a_no_result_at_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operand_a != '0) && (in_operand_b != '0) |=> !out_valid)
    else $error("result in cycle after accept");

endmodule

bind gcd_lcm_unit gclu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_gclu_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .in_operand_a          (in_operand_a),
  .in_operand_b          (in_operand_b),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_gcd_value         (out_gcd_value),
  .out_lcm_value         (out_lcm_value),
  .out_product_overflows (out_product_overflows)
);

`default_nettype wire
